>>> rtl/core/bitmap_slot_allocator_defines.svh
// ----------------------------------------------------------------------------
// Bitmap slot allocator assertion macros
// Shared concurrent assertion forms used by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

// Implication or plain property checked on every rising clock edge out of reset.
`define BSA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true on a rising clock edge out of reset.
`define BSA_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/core/bsa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Shared constants, codes, control structs and bit search functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

  localparam int CHUNK_BITS = 64;
  localparam int BIT_W      = 6;
  localparam int CFG_W      = 5;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef struct packed {
    logic free_en;
    logic rescan;
  } cmd_t;

  typedef struct packed {
    logic grant;
    logic full;
    logic bad;
    logic mark;
  } rpt_t;

  function automatic logic [BIT_W-1:0] lowest_one(input logic [CHUNK_BITS-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

  function automatic logic [BIT_W-1:0] highest_one(input logic [CHUNK_BITS-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < CHUNK_BITS; i++) begin
      if (w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/bsa_cell.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator chunk cell
// Holds one 64-slot free bitmap chunk and relays the upward allocation
// search and the downward high mark search to its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsa_cell #(
  parameter int MAX_CHUNKS = 16,
  parameter int CELL_ID    = 0
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic [$clog2(MAX_CHUNKS+1)-1:0]        n_i,
  input  wire bsa_pkg::cmd_t                          cmd_i,
  input  wire logic [(MAX_CHUNKS > 1 ? $clog2(MAX_CHUNKS) : 1)-1:0] chunk_i,
  input  wire logic [bsa_pkg::BIT_W-1:0]              bit_i,
  input  wire logic                                   up_i,
  output logic                                        up_o,
  input  wire logic                                   dn_i,
  output logic                                        dn_o,
  output bsa_pkg::rpt_t                               rpt_o,
  output logic [$clog2(MAX_CHUNKS*64+1)-1:0]          value_o
);
  import bsa_pkg::*;

  localparam int SlotW  = $clog2(MAX_CHUNKS * CHUNK_BITS + 1);
  localparam int ChunkW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

  logic [CHUNK_BITS-1:0] word_q, word_d;
  logic                  up_q, dn_q;

  logic             in_range, next_in_range, empty, all_free, sel, bad;
  logic [BIT_W-1:0] lo, hi;

  always_comb begin
    in_range      = CELL_ID < int'(n_i);
    next_in_range = (CELL_ID + 1) < int'(n_i);
    empty         = word_q == '0;
    all_free      = word_q == '1;
    sel           = cmd_i.free_en && (chunk_i == ChunkW'(CELL_ID));
    bad           = sel && word_q[bit_i];
    lo            = lowest_one(word_q);
    hi            = highest_one(~word_q);

    rpt_o.grant = up_q && in_range && !empty;
    rpt_o.full  = up_q && (!in_range || (empty && !next_in_range));
    rpt_o.bad   = bad;
    rpt_o.mark  = dn_q && (empty || !all_free || CELL_ID == 0);

    up_o = up_q && in_range && empty && next_in_range;
    dn_o = dn_q && all_free && CELL_ID != 0;

    if (rpt_o.grant) begin
      value_o = SlotW'(CELL_ID * CHUNK_BITS + int'(lo) + 1);
    end else if (rpt_o.mark && empty) begin
      value_o = SlotW'((CELL_ID + 1) * CHUNK_BITS);
    end else if (rpt_o.mark && !all_free) begin
      value_o = SlotW'(CELL_ID * CHUNK_BITS + int'(hi) + 1);
    end else begin
      value_o = '0;
    end

    word_d = word_q;
    if (rpt_o.grant) begin
      word_d[lo] = 1'b0;
    end
    if (sel && !bad) begin
      word_d[bit_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '1;
      up_q   <= 1'b0;
      dn_q   <= 1'b0;
    end else begin
      word_q <= word_d;
      up_q   <= up_i;
      dn_q   <= dn_i || (sel && !bad && cmd_i.rescan);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bitmap_slot_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator
// Allocates and frees 1-based slots from a pool of 64-slot chunks and
// tracks the greatest occupied slot as a high mark.
// ----------------------------------------------------------------------------
// Requests enter on the input channel (in_valid_i, in_stall_o) with kind_i
// and slot_index_i; one result per request leaves on the output channel
// (out_valid_o, out_stall_i) with status_o, granted_index_o and high_mark_o.
// The chunk count register is written through cfg_valid_i/cfg_data_i and is
// always ready; the user must write it only while no request is in flight,
// as the block itself does not enforce this. One request is in flight at a
// time. An allocate searches up from chunk 0, one cell per cycle, until a
// chunk k grants a slot or the pool reports full. A free marks its slot free
// and, when it frees the high mark slot, searches the high mark down from
// chunk c to chunk c'. A free with an index out of range is answered as bad
// without reaching the cells. The next request is taken in the cycle after
// the result moves to the output register.
// Reset marks every slot free, clears the high mark and sets the chunk count
// to 16. A stalled result holds in the output register, and a finished result
// waits in the controller until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_slot_allocator_defines.svh"

module bitmap_slot_allocator #(
  parameter int MAX_CHUNKS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [bsa_pkg::CFG_W-1:0]            cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 kind_i,
  input  wire logic [$clog2(MAX_CHUNKS*64+1)-1:0]   slot_index_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [1:0]                                status_o,
  output logic [$clog2(MAX_CHUNKS*64+1)-1:0]        granted_index_o,
  output logic [$clog2(MAX_CHUNKS*64+1)-1:0]        high_mark_o
);
  import bsa_pkg::*;

  localparam int SlotW  = $clog2(MAX_CHUNKS * CHUNK_BITS + 1);
  localparam int ChunkW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int NW     = $clog2(MAX_CHUNKS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [CFG_W-1:0]   chunks_q, chunks_d;
  logic [SlotW-1:0]   hm_q, hm_d;
  logic [ChunkW-1:0]  chunk_q, chunk_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic               rescan_q, rescan_d;
  status_e            res_status_q, res_status_d;
  logic [SlotW-1:0]   res_gr_q, res_gr_d;
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [SlotW-1:0]   out_gr_q, out_gr_d;
  logic [SlotW-1:0]   out_hm_q, out_hm_d;

  logic [NW-1:0]      n_act;
  logic [SlotW-1:0]   idx_m1;
  logic               up_start;
  cmd_t               cmd;
  logic [MAX_CHUNKS:0] up_chain;
  logic [MAX_CHUNKS:0] dn_chain;
  rpt_t               rpt_c [MAX_CHUNKS];
  logic [SlotW-1:0]   val_c [MAX_CHUNKS];
  rpt_t               rpt_or;
  logic [SlotW-1:0]   val_or;
  logic [MAX_CHUNKS-1:0] rpt_hit;

  assign up_chain[0]          = up_start;
  assign dn_chain[MAX_CHUNKS] = 1'b0;

  for (genvar g = 0; g < MAX_CHUNKS; g++) begin : g_cell
    bsa_cell #(
      .MAX_CHUNKS(MAX_CHUNKS),
      .CELL_ID   (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .n_i    (n_act),
      .cmd_i  (cmd),
      .chunk_i(chunk_q),
      .bit_i  (bit_q),
      .up_i   (up_chain[g]),
      .up_o   (up_chain[g+1]),
      .dn_i   (dn_chain[g+1]),
      .dn_o   (dn_chain[g]),
      .rpt_o  (rpt_c[g]),
      .value_o(val_c[g])
    );
  end

  always_comb begin
    rpt_or = '0;
    val_or = '0;
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      rpt_or     = rpt_or | rpt_c[i];
      val_or     = val_or | val_c[i];
      rpt_hit[i] = |rpt_c[i];
    end
  end

  always_comb begin
    if (chunks_q == '0) begin
      n_act = NW'(1);
    end else if (int'(chunks_q) > MAX_CHUNKS) begin
      n_act = NW'(MAX_CHUNKS);
    end else begin
      n_act = NW'(chunks_q);
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign in_stall_o      = state_q != S_IDLE;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign granted_index_o = out_gr_q;
  assign high_mark_o     = out_hm_q;

  always_comb begin
    state_d      = state_q;
    chunks_d     = chunks_q;
    hm_d         = hm_q;
    chunk_d      = chunk_q;
    bit_d        = bit_q;
    rescan_d     = rescan_q;
    res_status_d = res_status_q;
    res_gr_d     = res_gr_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_gr_d     = out_gr_q;
    out_hm_d     = out_hm_q;
    up_start     = 1'b0;
    cmd          = '0;
    idx_m1       = slot_index_i - SlotW'(1);

    if (cfg_valid_i) begin
      chunks_d = cfg_data_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_gr_d = '0;
          if (kind_i == KIND_ALLOC) begin
            up_start = 1'b1;
            state_d  = S_ALLOC;
          end else if (slot_index_i == '0 ||
                       int'(slot_index_i) > int'(n_act) * CHUNK_BITS) begin
            res_status_d = ST_BAD;
            state_d      = S_DONE;
          end else begin
            chunk_d  = idx_m1[BIT_W +: ChunkW];
            bit_d    = idx_m1[BIT_W-1:0];
            rescan_d = slot_index_i == hm_q;
            state_d  = S_FREE;
          end
        end
      end
      S_ALLOC: begin
        if (rpt_or.grant) begin
          res_status_d = ST_OK;
          res_gr_d     = val_or;
          if (val_or > hm_q) begin
            hm_d = val_or;
          end
          state_d = S_DONE;
        end else if (rpt_or.full) begin
          res_status_d = ST_FULL;
          res_gr_d     = '0;
          state_d      = S_DONE;
        end
      end
      S_FREE: begin
        cmd.free_en = 1'b1;
        cmd.rescan  = rescan_q;
        if (rpt_or.bad) begin
          res_status_d = ST_BAD;
          state_d      = S_DONE;
        end else begin
          res_status_d = ST_OK;
          state_d      = rescan_q ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (rpt_or.mark) begin
          hm_d    = val_or;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_gr_d     = res_gr_q;
          out_hm_d     = hm_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      chunks_q     <= CFG_W'(16);
      hm_q         <= '0;
      chunk_q      <= '0;
      bit_q        <= '0;
      rescan_q     <= 1'b0;
      res_status_q <= ST_OK;
      res_gr_q     <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_gr_q     <= '0;
      out_hm_q     <= '0;
    end else begin
      state_q      <= state_d;
      chunks_q     <= chunks_d;
      hm_q         <= hm_d;
      chunk_q      <= chunk_d;
      bit_q        <= bit_d;
      rescan_q     <= rescan_d;
      res_status_q <= res_status_d;
      res_gr_q     <= res_gr_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_gr_q     <= out_gr_d;
      out_hm_q     <= out_hm_d;
    end
  end

  `BSA_ASSERT(a_one_reporter, clk_i, rst_ni, $onehot0(rpt_hit), "Two cells reported at once.")
  `BSA_NEVER(a_up_end, clk_i, rst_ni, up_chain[MAX_CHUNKS], "Search ran past the last cell.")
  `BSA_NEVER(a_dn_end, clk_i, rst_ni, dn_chain[0], "High mark search ran below cell zero.")
  `BSA_ASSERT(a_alloc_rpt, clk_i, rst_ni, (rpt_or.grant || rpt_or.full) |-> (state_q == S_ALLOC), "Allocation report outside an allocation.")
  `BSA_ASSERT(a_mark_rpt, clk_i, rst_ni, rpt_or.mark |-> (state_q == S_SCAN), "High mark report outside a rescan.")

endmodule

`default_nettype wire
